FILE: design/mpls_label_stack_classifier_core_macros.svh
// Assertion macros for the MPLS label stack classifier checker.
// No dependencies; included by the checker file.
`ifndef MPLS_LABEL_STACK_CLASSIFIER_CORE_MACROS_SVH
`define MPLS_LABEL_STACK_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication, masked while in reset
`define MLSC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlsc assertion failed");

// next-cycle implication, masked while in reset
`define MLSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlsc assertion failed");

// next-cycle implication that is checked through reset as well
`define MLSC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mlsc assertion failed");

`endif

FILE: design/mlsc_pkg.sv
// Shared types and constants of the MPLS label stack classifier.
// No dependencies.
`timescale 1ns / 1ps

package mlsc_pkg;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_STACK = 2'd1,
        PH_AWAIT = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    localparam logic [3:0] V_IPV4          = 4'd0;
    localparam logic [3:0] V_IPV6          = 4'd1;
    localparam logic [3:0] V_IPV4_GUESS    = 4'd2;
    localparam logic [3:0] V_IPV6_GUESS    = 4'd3;
    localparam logic [3:0] V_ETH_PW        = 4'd4;
    localparam logic [3:0] V_TOO_SMALL     = 4'd5;
    localparam logic [3:0] V_ROUTER_ALERT  = 4'd6;
    localparam logic [3:0] V_IMPLICIT_NULL = 4'd7;
    localparam logic [3:0] V_RESERVED      = 4'd8;
    localparam logic [3:0] V_UNKNOWN       = 4'd9;

    localparam logic [19:0] LABEL_IPV4          = 20'd0;
    localparam logic [19:0] LABEL_ROUTER_ALERT  = 20'd1;
    localparam logic [19:0] LABEL_IPV6          = 20'd2;
    localparam logic [19:0] LABEL_IMPLICIT_NULL = 20'd3;
    localparam logic [19:0] RESERVED_LIMIT      = 20'd15;

    localparam logic [3:0] NIB_ETH_PW = 4'h0;
    localparam logic [3:0] NIB_IPV4   = 4'h4;
    localparam logic [3:0] NIB_IPV6   = 4'h6;

    localparam int PW_HEADER_BYTES = 4;
    localparam int OFFSET_OUT_W    = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [3:0]              verdict;
        logic [OFFSET_OUT_W-1:0] inner_offset;
        logic [19:0]             bottom_label;
        logic [7:0]              stack_depth;
    } result_t;

    typedef struct packed {
        logic    push;
        result_t item;
    } push_t;

endpackage

FILE: design/mlsc_queue.sv
// Small verdict queue between parser and output stage.
// Depends on mlsc_pkg.
`timescale 1ns / 1ps

module mlsc_queue
    import mlsc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   wr,
    output logic    full,
    output logic    rd_valid,
    output result_t rd_item,
    input  logic    rd_pop
);

    result_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign do_push  = wr.push && !full;
    assign do_pop   = rd_pop && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= wr.item;
        end
    end

endmodule

FILE: design/mlsc_front.sv
// Front end: accepts payload bytes, assembles shims and classifies the stack.
// Depends on mlsc_pkg; pushes verdicts into mlsc_queue.
`timescale 1ns / 1ps

module mlsc_front
    import mlsc_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_first_byte,
    input  logic       s_last_byte,
    input  logic       q_full,
    output push_t      wr
);

    // offset saturates at all ones of this width
    localparam int OFF_W = (OFFSET_BITS < OFFSET_OUT_W) ? OFFSET_BITS : OFFSET_OUT_W;

    phase_t           phase_reg, phase_next;
    logic [23:0]      shim_reg, shim_next;
    logic [1:0]       bis_reg, bis_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [7:0]       cnt_reg, cnt_next;
    logic [19:0]      held_reg, held_next;

    logic             accept;
    phase_t           eff_phase;
    logic [23:0]      eff_shim;
    logic [1:0]       eff_bis;
    logic [OFF_W-1:0] eff_off;
    logic [7:0]       eff_cnt;
    logic [19:0]      eff_held;

    logic [OFF_W:0]   off_sum1, off_sum4;
    logic [OFF_W-1:0] off_inc, off_pw;
    logic [7:0]       cnt_inc;
    logic [19:0]      label;
    logic             bottom;
    logic [3:0]       nib;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // a first byte restarts parsing in the stack phase with all parser state cleared
    assign eff_phase = s_first_byte ? PH_STACK : phase_reg;
    assign eff_shim  = s_first_byte ? '0 : shim_reg;
    assign eff_bis   = s_first_byte ? '0 : bis_reg;
    assign eff_off   = s_first_byte ? '0 : off_reg;
    assign eff_cnt   = s_first_byte ? '0 : cnt_reg;
    assign eff_held  = s_first_byte ? '0 : held_reg;

    assign off_sum1 = {1'b0, eff_off} + (OFF_W+1)'(1);
    assign off_sum4 = {1'b0, eff_off} + (OFF_W+1)'(PW_HEADER_BYTES);
    assign off_inc  = off_sum1[OFF_W] ? '1 : off_sum1[OFF_W-1:0];
    assign off_pw   = off_sum4[OFF_W] ? '1 : off_sum4[OFF_W-1:0];
    assign cnt_inc  = (eff_cnt == 8'hFF) ? eff_cnt : eff_cnt + 1'b1;
    assign label    = eff_shim[23:4];
    assign bottom   = eff_shim[0];
    assign nib      = s_data_byte[7:4];

    // next state
    always_comb begin
        phase_next = phase_reg;
        shim_next  = shim_reg;
        bis_next   = bis_reg;
        off_next   = off_reg;
        cnt_next   = cnt_reg;
        held_next  = held_reg;
        if (accept) begin
            shim_next = eff_shim;
            bis_next  = eff_bis;
            off_next  = eff_off;
            cnt_next  = eff_cnt;
            held_next = eff_held;
            unique case (eff_phase)
                PH_IDLE: begin
                    phase_next = PH_IDLE;
                end
                PH_DONE, PH_AWAIT: begin
                    phase_next = s_last_byte ? PH_IDLE : PH_DONE;
                end
                PH_STACK: begin
                    off_next = off_inc;
                    if (eff_bis != 2'd3) begin
                        shim_next  = {eff_shim[15:0], s_data_byte};
                        bis_next   = eff_bis + 1'b1;
                        phase_next = s_last_byte ? PH_IDLE : PH_STACK;
                    end else begin
                        shim_next = '0;
                        bis_next  = '0;
                        cnt_next  = cnt_inc;
                        if (!bottom) begin
                            phase_next = s_last_byte ? PH_IDLE : PH_STACK;
                        end else if (label < RESERVED_LIMIT) begin
                            phase_next = s_last_byte ? PH_IDLE : PH_DONE;
                        end else begin
                            held_next  = label;
                            phase_next = s_last_byte ? PH_IDLE : PH_AWAIT;
                        end
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // verdict output
    always_comb begin
        wr.push              = 1'b0;
        wr.item.verdict      = V_TOO_SMALL;
        wr.item.inner_offset = '0;
        wr.item.bottom_label = '0;
        wr.item.stack_depth  = eff_cnt;
        unique case (eff_phase)
            PH_IDLE, PH_DONE: begin
                wr.push = 1'b0;
            end
            PH_AWAIT: begin
                wr.push              = accept;
                wr.item.inner_offset = OFFSET_OUT_W'(eff_off);
                wr.item.bottom_label = eff_held;
                unique case (nib)
                    NIB_IPV4: wr.item.verdict = V_IPV4_GUESS;
                    NIB_IPV6: wr.item.verdict = V_IPV6_GUESS;
                    NIB_ETH_PW: begin
                        wr.item.verdict      = V_ETH_PW;
                        wr.item.inner_offset = OFFSET_OUT_W'(off_pw);
                    end
                    default: wr.item.verdict = V_UNKNOWN;
                endcase
            end
            PH_STACK: begin
                if (eff_bis != 2'd3) begin
                    wr.push = accept && s_last_byte;
                end else if (!bottom) begin
                    wr.push             = accept && s_last_byte;
                    wr.item.stack_depth = cnt_inc;
                end else begin
                    wr.item.stack_depth  = cnt_inc;
                    wr.item.inner_offset = OFFSET_OUT_W'(off_inc);
                    wr.item.bottom_label = label;
                    if (label < RESERVED_LIMIT) begin
                        wr.push = accept;
                        unique case (label)
                            LABEL_IPV4:          wr.item.verdict = V_IPV4;
                            LABEL_ROUTER_ALERT:  wr.item.verdict = V_ROUTER_ALERT;
                            LABEL_IPV6:          wr.item.verdict = V_IPV6;
                            LABEL_IMPLICIT_NULL: wr.item.verdict = V_IMPLICIT_NULL;
                            default:             wr.item.verdict = V_RESERVED;
                        endcase
                    end else begin
                        // push only if the bottom shim ends the packet: no payload byte to look at
                        wr.push         = accept && s_last_byte;
                        wr.item.verdict = V_UNKNOWN;
                    end
                end
            end
            default: begin
                wr.push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            shim_reg  <= '0;
            bis_reg   <= '0;
            off_reg   <= '0;
            cnt_reg   <= '0;
            held_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            shim_reg  <= shim_next;
            bis_reg   <= bis_next;
            off_reg   <= off_next;
            cnt_reg   <= cnt_next;
            held_reg  <= held_next;
        end
    end

endmodule

FILE: design/mlsc_back.sv
// Back end: pops verdicts from the queue into the output register.
// Depends on mlsc_pkg.
`timescale 1ns / 1ps

module mlsc_back
    import mlsc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    input  result_t q_item,
    output logic    q_pop,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_item
);

    logic    valid_reg, valid_next;
    result_t item_reg;

    // refill whenever the register is empty or being drained this cycle
    assign q_pop = q_valid && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg;
        if (q_pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_item;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

FILE: design/mpls_label_stack_classifier_core.sv
// MPLS label stack classifier, top level.
//
// Input channel s_*: one payload byte per transfer, wire order; s_first_byte
// marks a packet start (it restarts parsing), s_last_byte the packet end.
// Output channel m_*: at most one verdict per packet with inner offset,
// bottom label and stack depth.
//
// Throughput: one byte per cycle while the queue is not full; the parser
// handles each byte with compares and a saturating add.
// Path: the transfer edge of the byte that settles a verdict writes it into
// the queue, and it moves on into the output register that drives m_valid
// once that register is empty or being drained.
// Stall: when m_ready is low the output register holds its verdict and the
// four-entry queue absorbs new ones; s_ready drops only when the queue is
// full.
// Reset: aresetn low (synchronous) empties queue and output register and
// returns the parser to idle, waiting for a first byte.
// Depends on mlsc_pkg, mlsc_front, mlsc_queue, mlsc_back.
`timescale 1ns / 1ps

module mpls_label_stack_classifier_core
    import mlsc_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_verdict,
    output logic [15:0] m_inner_offset,
    output logic [19:0] m_bottom_label,
    output logic [7:0]  m_stack_depth
);

    push_t   wr;
    logic    q_full, q_valid, q_pop;
    result_t q_item, m_item;

    mlsc_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_first_byte(s_first_byte),
        .s_last_byte (s_last_byte),
        .q_full      (q_full),
        .wr          (wr)
    );

    mlsc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .full    (q_full),
        .rd_valid(q_valid),
        .rd_item (q_item),
        .rd_pop  (q_pop)
    );

    mlsc_back u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .q_valid(q_valid),
        .q_item (q_item),
        .q_pop  (q_pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    assign m_verdict      = m_item.verdict;
    assign m_inner_offset = m_item.inner_offset;
    assign m_bottom_label = m_item.bottom_label;
    assign m_stack_depth  = m_item.stack_depth;

endmodule

FILE: design/mlsc_checker.sv
// Port-level checks of the MPLS label stack classifier, bound to the top level.
// Depends on mlsc_pkg and mpls_label_stack_classifier_core_macros.svh.
`timescale 1ns / 1ps
`include "mpls_label_stack_classifier_core_macros.svh"

module mlsc_checker
    import mlsc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_data_byte,
    input logic        s_first_byte,
    input logic        s_last_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_verdict,
    input logic [15:0] m_inner_offset,
    input logic [19:0] m_bottom_label,
    input logic [7:0]  m_stack_depth
);

    `MLSC_ASSERT_NEXT_ALWAYS(a_reset_clears_out, aclk, !aresetn, !m_valid)
    `MLSC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable({m_verdict, m_inner_offset, m_bottom_label, m_stack_depth}))
    `MLSC_ASSERT_IMPLIES(a_verdict_range, aclk, aresetn, m_valid, m_verdict <= V_UNKNOWN)
    `MLSC_ASSERT_IMPLIES(a_too_small_zero, aclk, aresetn, m_valid && (m_verdict == V_TOO_SMALL), (m_inner_offset == '0) && (m_bottom_label == '0))
    `MLSC_ASSERT_IMPLIES(a_pw_offset, aclk, aresetn, m_valid && (m_verdict == V_ETH_PW), (m_inner_offset >= 16'(PW_HEADER_BYTES)) && (m_stack_depth != '0))

endmodule

bind mpls_label_stack_classifier_core mlsc_checker u_mlsc_checker (.*);
